// ===== rtl/npc_pkg.sv =====
// Shared types and constants of the nearest palette color block.
`timescale 1ns / 1ps

package npc_pkg;

    // Default palette depth and channel width.
    localparam int DEFAULT_ENTRIES = 256;
    localparam int COLOR_W         = 8;
    localparam int INDEX_W         = 8;
    localparam int SQUARE_W        = 2 * COLOR_W;
    localparam int DIST_W          = SQUARE_W + 2;

    // Operation codes carried in the request beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One palette color.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    // Control flags that travel with each entry fed to the distance unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_ctl_t;

endpackage

// ===== rtl/npc_ifs.sv =====
// Request and response channel interfaces of the nearest palette color block.
`timescale 1ns / 1ps

interface npc_req_if
    import npc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (
        output valid, opcode, entry_index, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, red, green, blue,
        output ready
    );
endinterface

interface npc_rsp_if
    import npc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] nearest_index;

    modport source (
        output valid, nearest_index,
        input  ready
    );
    modport sink (
        input  valid, nearest_index,
        output ready
    );
endinterface

// ===== rtl/npc_cell.sv =====
// One palette cell of the rotating palette ring.
`timescale 1ns / 1ps

module npc_cell
    import npc_pkg::*;
(
    input  logic   clk,
    input  logic   shift_en,
    input  color_t shift_in,
    input  logic   load_en,
    input  color_t load_data,
    output color_t data
);

    color_t data_reg;

    // During a search the entry moves one place along the ring; a load
    // overwrites it while the ring stands still.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= shift_in;
        end
        else if (load_en)
        begin
            data_reg <= load_data;
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/npc_dist.sv =====
// Two-stage squared distance and running minimum unit at the head of the ring.
`timescale 1ns / 1ps

module npc_dist
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_ENTRIES,
    localparam int IdxW = $clog2(PALETTE_ENTRIES)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  color_t          query,
    input  color_t          entry,
    input  logic [IdxW-1:0] entry_idx,
    input  scan_ctl_t       ctl,
    output logic            done,
    output logic [IdxW-1:0] best_idx
);

    logic [SQUARE_W-1:0] sq_r_reg;
    logic [SQUARE_W-1:0] sq_g_reg;
    logic [SQUARE_W-1:0] sq_b_reg;
    logic [IdxW-1:0]     idx_reg;
    scan_ctl_t           ctl_reg;
    logic [DIST_W-1:0]   best_reg;
    logic [IdxW-1:0]     best_idx_reg;
    logic                done_reg;

    logic [COLOR_W-1:0]  diff_r;
    logic [COLOR_W-1:0]  diff_g;
    logic [COLOR_W-1:0]  diff_b;
    logic [DIST_W-1:0]   dist_next;

    // Absolute channel differences.
    always_comb
    begin
        diff_r = (entry.red >= query.red) ? entry.red - query.red : query.red - entry.red;
        diff_g = (entry.green >= query.green) ? entry.green - query.green
                                              : query.green - entry.green;
        diff_b = (entry.blue >= query.blue) ? entry.blue - query.blue
                                            : query.blue - entry.blue;
    end

    // Stage one: square each channel difference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQUARE_W'(diff_r) * SQUARE_W'(diff_r);
        sq_g_reg <= SQUARE_W'(diff_g) * SQUARE_W'(diff_g);
        sq_b_reg <= SQUARE_W'(diff_b) * SQUARE_W'(diff_b);
        idx_reg  <= entry_idx;
    end

    // Stage two: sum the squares and keep the first strict minimum.
    assign dist_next = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_ff @(posedge clk)
    begin
        if (ctl_reg.valid && (ctl_reg.first || (dist_next < best_reg)))
        begin
            best_reg     <= dist_next;
            best_idx_reg <= idx_reg;
        end
    end

    // Done rises once the last entry has been compared and drops at the
    // start of the next search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (ctl_reg.valid && ctl_reg.last)
        begin
            done_reg <= 1'b1;
        end
        else if (ctl_reg.valid && ctl_reg.first)
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== rtl/nearest_palette_color_core.sv =====
// Top level of the nearest palette color block: palette ring, control and output register.
`timescale 1ns / 1ps

// The palette is a ring of PALETTE_ENTRIES cells. A load beat writes one cell;
// loads to an index at or beyond PALETTE_ENTRIES are dropped and give no
// response. A query beat rotates the ring once, one entry per cycle, past a
// two-stage distance unit that keeps the lowest index with the smallest
// squared RGB distance; no new request is taken until the answer is in the
// output register, and the full rotation leaves every entry where it was
// loaded. The answer waits in an output register, so loads are still taken
// while it is unread.
// All entries must be loaded before the first query.
module nearest_palette_color_core
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic   clk,
    input  logic   rst_n,
    npc_req_if.sink   req,
    npc_rsp_if.source rsp
);

    localparam int IdxW = $clog2(PALETTE_ENTRIES);
    localparam logic [IdxW-1:0] LastStep = IdxW'(PALETTE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

    state_t             state_reg;
    logic [IdxW-1:0]    step_reg;
    color_t             query_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_idx_reg;

    color_t             cell_q [PALETTE_ENTRIES];
    color_t             req_color;
    logic               accept;
    logic               accept_load;
    logic               shift_en;
    scan_ctl_t          scan_ctl;
    logic               dist_done;
    logic [IdxW-1:0]    dist_best;

    // Request decode.
    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign accept_load = accept && (req.opcode == OP_LOAD);
    assign req_color   = '{red: req.red, green: req.green, blue: req.blue};
    assign shift_en    = (state_reg == ST_SCAN);

    // Palette ring: each cell takes its upper neighbor, the last wraps to the head.
    for (genvar k = 0; k < PALETTE_ENTRIES; k++)
    begin : g_cell
        localparam int Nxt = (k + 1) % PALETTE_ENTRIES;

        npc_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .shift_in  (cell_q[Nxt]),
            .load_en   (accept_load && (req.entry_index == INDEX_W'(k))),
            .load_data (req_color),
            .data      (cell_q[k])
        );
    end

    // Scan flags for the entry now at the head of the ring.
    assign scan_ctl = '{valid: shift_en,
                        first: (step_reg == '0),
                        last:  (step_reg == LastStep)};

    npc_dist #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_reg),
        .entry     (cell_q[0]),
        .entry_idx (step_reg),
        .ctl       (scan_ctl),
        .done      (dist_done),
        .best_idx  (dist_best)
    );

    // Query color is captured with the request beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= req_color;
        end
    end

    // Sequencer with the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            // The response beat leaves unless a new answer replaces it at once.
            if (rsp.valid && rsp.ready && !((state_reg == ST_WAIT) && dist_done))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept && (req.opcode == OP_QUERY))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LastStep)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (dist_done && (!out_valid_reg || rsp.ready))
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= INDEX_W'(dist_best);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.nearest_index = out_idx_reg;

endmodule
